// ----- rtl/assert_macros.svh -----
// Assertion macros used by the core RTL file of the line justifier.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, masked while reset is high.
`define GLJ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen on a rising edge.
`define GLJ_NEVER(lbl, clk, rst, cond, msg) \
  `GLJ_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

// ----- rtl/glj_pkg.sv -----
// Types and fixed constants of the greedy line justifier.
// No dependencies; imported by the core, front, queue and back modules.
package glj_pkg;

  localparam int LEN_W  = 7;  // word length field
  localparam int CNT_W  = 6;  // words per line, up to the largest buffer
  localparam int COL_W  = 7;  // columns inside a line, up to the widest line
  localparam int SUM_W  = COL_W + 1;
  localparam int COLF_W = 6;  // column and space fields of a result
  localparam int CFG_W  = 7;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = 1;
  localparam int CMDQ_CW    = 2;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 7'd64;
  // word index of the line width register (paddr[2])
  localparam logic [0:0] REG_LINE_WIDTH = 1'b0;

  typedef struct packed {
    logic [LEN_W-1:0] word_length;
    logic             last_word;
  } item_t;

  typedef struct packed {
    logic [LEN_W-1:0]  placed_length;
    logic [COLF_W-1:0] start_column;
    logic [COLF_W-1:0] spaces_after;
    logic              line_end;
    logic              final_line;
    logic              last_of_run;
  } result_t;

  // one classified word, front to back
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] wr_idx;
    logic             close;       // open line is closed before this word
    logic [CNT_W-1:0] close_n;
    logic [COL_W-1:0] close_used;
    logic             last;        // final line closed after this word
    logic [CNT_W-1:0] fin_n;
    logic [COL_W-1:0] fin_used;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [COL_W-1:0] used;
  } front_stat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_READ,
    B_PUT,
    B_WRITE
  } back_state_t;

endpackage

// ----- rtl/greedy_line_justifier_core.sv -----
// Greedy full-justification line packer. Word lengths are pushed one per request and
// packed into lines of line_width columns (register 0, reset 64, clamped to 1..MAX_WIDTH);
// a word that does not fit, or arrives with LINE_WORDS words already open, closes the line,
// and the final word closes a left-justified last line. Each placed word pops out as one
// result with its start column and the spaces after it. The front classifies a word
// combinationally and hands it over a two-entry queue; the back fetches each request in its
// idle state and writes it into the line buffer in its write state, then emits each word
// through a read state and a put state, paced by the buffer's registered read port and held
// while the result is not taken. A closed line with two or more words also waits for the
// serial gap divider before its first word. Pushing stalls only when the queue is full, so
// bursts of short words are absorbed while a line drains. Configuration writes are expected only while the block idles.
// Depends on glj_pkg, glj_front, glj_cmdq, glj_back and assert_macros.svh.
`include "assert_macros.svh"

module greedy_line_justifier_core
  import glj_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int LINE_WORDS = 32
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // word requests
  input  logic              push,
  output logic              full,
  input  item_t             item,
  // placement results
  output logic              empty,
  input  logic              pop,
  output result_t           result
);

  logic [CFG_W-1:0] line_width;
  logic [COL_W-1:0] width;
  logic             reg_sel;

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  cmd_t             cmd_in;
  cmd_t             cmd_out;
  front_stat_t      fstat;

  // register file: a single word-aligned register, paddr[1:0] ignored
  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1:2] == REG_LINE_WIDTH;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      line_width <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = reg_sel ? DATA_W'(line_width) : '0;

  // effective width: zero reads as one, anything past the widest line saturates
  always_comb begin
    if (line_width == '0) begin
      width = COL_W'(1);
    end else if (line_width > CFG_W'(MAX_WIDTH)) begin
      width = COL_W'(MAX_WIDTH);
    end else begin
      width = line_width;
    end
  end

  glj_front #(
    .LINE_WORDS(LINE_WORDS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .width (width),
    .push  (push),
    .item  (item),
    .full  (full),
    .q_full(q_full),
    .q_push(q_push),
    .cmd   (cmd_in),
    .stat  (fstat)
  );

  glj_cmdq u_cmdq (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (cmd_in),
    .full (q_full),
    .pop  (q_pop),
    .dout (cmd_out),
    .empty(q_empty)
  );

  glj_back #(
    .LINE_WORDS(LINE_WORDS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .width  (width),
    .cmd    (cmd_out),
    .q_empty(q_empty),
    .q_pop  (q_pop),
    .result (result),
    .empty  (empty),
    .pop    (pop)
  );

  // a word marked last leaves no open line behind
  `GLJ_ASSERT(a_last_clears, clk, rst, (push && !full && item.last_word) |=> (fstat.count == '0), "open line survived a last word")
  // the open line never holds more words than the buffer
  `GLJ_ASSERT(a_count_bound, clk, rst, fstat.count <= CNT_W'(LINE_WORDS), "line buffer overrun")
  // an empty line carries no used columns
  `GLJ_ASSERT(a_empty_line, clk, rst, (fstat.count == '0) |-> (fstat.used == '0), "used columns on an empty line")
  // every result shows a word of at least one character
  `GLJ_NEVER(a_zero_word, clk, rst, !empty && result.placed_length == '0, "zero-length word placed")

endmodule

// ----- rtl/glj_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module glj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/glj_div.sv -----
// Restoring divider, one quotient bit per cycle, for the gap spacing.
// Depends on nothing but its parameters.
module glj_div #(
  parameter int NUM_W = 7,
  parameter int DEN_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rmd
);

  localparam int SC_W = $clog2(NUM_W + 1);

  logic [SC_W-1:0]  steps;
  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   r;
  logic [DEN_W-1:0] d;
  logic [DEN_W:0]   shifted;
  logic             ge;

  assign shifted = {r[DEN_W-1:0], q[NUM_W-1]};
  assign ge      = shifted >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= SC_W'(NUM_W);
    end else if (busy) begin
      steps <= steps - SC_W'(1);
      if (steps == SC_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= num;
      r <= '0;
      d <= den;
    end else if (busy) begin
      r <= ge ? (shifted - {1'b0, d}) : shifted;
      q <= NUM_W'({q, ge});
    end
  end

  assign quo = q;
  assign rmd = r[DEN_W-1:0];

endmodule

// ----- rtl/glj_cmdq.sv -----
// Short queue of classified words between the front and back parts.
// Depends on glj_pkg.
module glj_cmdq
  import glj_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t               mem [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr;
  logic [CMDQ_AW-1:0] rptr;
  logic [CMDQ_CW-1:0] cnt;
  logic               do_push;
  logic               do_pop;

  assign full    = cnt == CMDQ_CW'(CMDQ_DEPTH);
  assign empty   = cnt == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + CMDQ_AW'(1);
      end
      if (do_pop) begin
        rptr <= rptr + CMDQ_AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CMDQ_CW'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CMDQ_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

endmodule

// ----- rtl/glj_front.sv -----
// Front part: clamps each word, tracks the open line and decides where lines close.
// Depends on glj_pkg; feeds glj_cmdq.
module glj_front
  import glj_pkg::*;
#(
  parameter int LINE_WORDS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [COL_W-1:0] width,
  input  logic             push,
  input  item_t            item,
  output logic             full,
  input  logic             q_full,
  output logic             q_push,
  output cmd_t             cmd,
  output front_stat_t      stat
);

  logic [CNT_W-1:0] count;
  logic [COL_W-1:0] used;
  logic [LEN_W-1:0] len;
  logic [SUM_W-1:0] sum;
  logic             close;
  logic [CNT_W-1:0] new_count;
  logic [COL_W-1:0] new_used;

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    if (item.word_length == '0) begin
      len = LEN_W'(1);
    end else if (item.word_length > width) begin
      len = width;
    end else begin
      len = item.word_length;
    end
  end

  // width of the open line if this word joins it
  assign sum   = SUM_W'(used) + SUM_W'(1) + SUM_W'(len);
  assign close = (count != '0) &&
                 ((count >= CNT_W'(LINE_WORDS)) || (sum > SUM_W'(width)));

  assign new_count = close ? CNT_W'(1) : count + CNT_W'(1);
  assign new_used  = (close || count == '0) ? len : sum[COL_W-1:0];

  always_comb begin
    cmd.len        = len;
    cmd.wr_idx     = close ? '0 : count;
    cmd.close      = close;
    cmd.close_n    = count;
    cmd.close_used = used;
    cmd.last       = item.last_word;
    cmd.fin_n      = new_count;
    cmd.fin_used   = new_used;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      used  <= '0;
    end else if (q_push) begin
      if (item.last_word) begin
        count <= '0;
        used  <= '0;
      end else begin
        count <= new_count;
        used  <= new_used;
      end
    end
  end

  assign stat.count = count;
  assign stat.used  = used;

endmodule

// ----- rtl/glj_back.sv -----
// Back part: buffers words of the open line and emits a burst of placements per line.
// Depends on glj_pkg, glj_ram and glj_div.
module glj_back
  import glj_pkg::*;
#(
  parameter int LINE_WORDS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [COL_W-1:0] width,
  input  cmd_t             cmd,
  input  logic             q_empty,
  output logic             q_pop,
  output result_t          result,
  output logic             empty,
  input  logic             pop
);

  localparam int AW = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;

  back_state_t      state;
  back_state_t      state_next;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] n;
  logic [COL_W-1:0] slack;
  logic [COL_W-1:0] col;
  logic             fin;
  logic             out_valid;
  result_t          out;

  logic [LEN_W-1:0] rdata;
  logic             ram_we;
  logic             div_start;
  logic             div_busy;
  logic [COL_W-1:0] quo;
  logic [CNT_W-1:0] rmd;

  logic             ln_fin;
  logic [CNT_W-1:0] ln_n;
  logic [COL_W-1:0] ln_used;
  logic [COL_W-1:0] ln_slack;
  logic             need_div;
  logic             load;
  logic             put;
  logic             out_free;
  logic             is_end;
  logic [COL_W-1:0] sp;
  result_t          res;

  glj_ram #(
    .WIDTH(LEN_W),
    .DEPTH(LINE_WORDS)
  ) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cmd.wr_idx[AW-1:0]),
    .wdata(cmd.len),
    .raddr(idx[AW-1:0]),
    .rdata(rdata)
  );

  glj_div #(
    .NUM_W(COL_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (ln_slack),
    .den  (ln_n - CNT_W'(1)),
    .busy (div_busy),
    .quo  (quo),
    .rmd  (rmd)
  );

  // line being opened for emission: closed line from idle, final line after the write
  assign ln_fin   = state == B_WRITE;
  assign ln_n     = ln_fin ? cmd.fin_n : cmd.close_n;
  assign ln_used  = ln_fin ? cmd.fin_used : cmd.close_used;
  assign ln_slack = (ln_used < width) ? width - ln_used : '0;
  assign need_div = !ln_fin && (ln_n > CNT_W'(1));

  assign out_free = !out_valid || pop;
  assign is_end   = idx == n - CNT_W'(1);

  always_comb begin
    if (is_end) begin
      sp = (fin || n == CNT_W'(1)) ? slack : '0;
    end else if (fin) begin
      sp = COL_W'(1);
    end else begin
      sp = COL_W'(1) + quo + COL_W'(idx < rmd);
    end
  end

  always_comb begin
    res.placed_length = rdata;
    res.start_column  = col[COLF_W-1:0];
    res.spaces_after  = sp[COLF_W-1:0];
    res.line_end      = is_end;
    res.final_line    = fin;
    res.last_of_run   = is_end && (fin || !cmd.last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    load       = 1'b0;
    div_start  = 1'b0;
    put        = 1'b0;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          if (cmd.close) begin
            load       = 1'b1;
            div_start  = need_div;
            state_next = need_div ? B_DIV : B_READ;
          end else begin
            state_next = B_WRITE;
          end
        end
      end
      B_DIV: begin
        if (!div_busy) begin
          state_next = B_READ;
        end
      end
      B_READ: begin
        state_next = B_PUT;
      end
      B_PUT: begin
        if (out_free) begin
          put = 1'b1;
          if (!is_end) begin
            state_next = B_READ;
          end else if (fin) begin
            q_pop      = 1'b1;
            state_next = B_IDLE;
          end else begin
            state_next = B_WRITE;
          end
        end
      end
      B_WRITE: begin
        ram_we = 1'b1;
        if (cmd.last) begin
          load       = 1'b1;
          state_next = B_READ;
        end else begin
          q_pop      = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idx   <= '0;
      col   <= '0;
      n     <= ln_n;
      slack <= ln_slack;
      fin   <= ln_fin;
    end else if (put && !is_end) begin
      idx <= idx + CNT_W'(1);
      col <= col + COL_W'(rdata) + sp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (put) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      out <= res;
    end
  end

  assign result = out;
  assign empty  = !out_valid;

endmodule
